// ===== rtl/core/bsw_pkg.sv =====
// Shared types, constants and lookup functions for the B-spline shape weight pipeline.
// Used by bspline_shape_weight_top and bsw_checker; depends on nothing.

package bsw_pkg;

    // Port and field widths
    localparam int OFFSET_W    = 32;
    localparam int S_TDATA_W   = 32;
    localparam int WEIGHT_W    = 17;
    localparam int WEIGHT_FRAC = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    // Configuration registers
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int ORDER_W     = 3;
    localparam int ICW_W       = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_SPLINE_ORDER   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_CELL_WIDTH = 1'd1;
    localparam logic [ORDER_W-1:0]     ORDER_RESET        = 3'd1;
    localparam logic [ICW_W-1:0]       ICW_RESET          = 32'd65536;

    // Polynomial evaluation
    localparam int NUM_COEFS    = 6;
    localparam int HORNER_STEPS = NUM_COEFS - 1;
    localparam int COEF_W       = 10;

    // Final division by den = 2^sh * m, m in {1, 3, 15}
    localparam int DEN_W       = 9;
    localparam int DEN_SH_W    = 3;
    localparam int DIV_M_W     = 4;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [DIV_M_W-1:0] DIV_BY_1  = 4'd1;
    localparam logic [DIV_M_W-1:0] DIV_BY_3  = 4'd3;
    localparam logic [DIV_M_W-1:0] DIV_BY_15 = 4'd15;

    // Polynomial segment selected for one item
    typedef enum logic [3:0] {
        SEG_OUT,
        SEG_O0,
        SEG_O1,
        SEG_O2A,
        SEG_O2B,
        SEG_O3A,
        SEG_O3B,
        SEG_O4A,
        SEG_O4B,
        SEG_O4C,
        SEG_O5A,
        SEG_O5B,
        SEG_O5C
    } seg_t;

    // Element [k] holds the coefficient of x^k
    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_row_t;

    typedef struct packed {
        logic [DEN_W-1:0]    den;
        logic [DEN_SH_W-1:0] sh;
        logic [DIV_M_W-1:0]  m;
    } div_info_t;

    // Integer coefficients, highest power first in the concatenation
    function automatic coef_row_t seg_coefs(input seg_t seg);
        coef_row_t row;
        unique case (seg)
            SEG_O0:  row = {10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd1};
            SEG_O1:  row = {10'sd0, 10'sd0, 10'sd0, 10'sd0, -10'sd1, 10'sd1};
            SEG_O2A: row = {10'sd0, 10'sd0, 10'sd0, -10'sd4, 10'sd0, 10'sd3};
            SEG_O2B: row = {10'sd0, 10'sd0, 10'sd0, 10'sd1, 10'sd0, 10'sd0};
            SEG_O3A: row = {10'sd0, 10'sd0, 10'sd3, -10'sd6, 10'sd0, 10'sd4};
            SEG_O3B: row = {10'sd0, 10'sd0, 10'sd1, 10'sd0, 10'sd0, 10'sd0};
            SEG_O4A: row = {10'sd0, 10'sd48, 10'sd0, -10'sd120, 10'sd0, 10'sd115};
            SEG_O4B: row = {10'sd0, -10'sd16, 10'sd80, -10'sd120, 10'sd20, 10'sd55};
            SEG_O4C: row = {10'sd0, 10'sd1, 10'sd0, 10'sd0, 10'sd0, 10'sd0};
            SEG_O5A: row = {-10'sd10, 10'sd30, 10'sd0, -10'sd60, 10'sd0, 10'sd66};
            SEG_O5B: row = {10'sd5, -10'sd45, 10'sd150, -10'sd210, 10'sd75, 10'sd51};
            SEG_O5C: row = {10'sd1, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 10'sd0};
            default: row = '0;
        endcase
        return row;
    endfunction

    // Denominator and its split into a shift and a small odd divisor
    function automatic div_info_t seg_div_info(input seg_t seg);
        div_info_t info;
        unique case (seg)
            SEG_O2A: info = '{den: 9'd4,   sh: 3'd2, m: DIV_BY_1};
            SEG_O2B: info = '{den: 9'd8,   sh: 3'd3, m: DIV_BY_1};
            SEG_O3A,
            SEG_O3B: info = '{den: 9'd6,   sh: 3'd1, m: DIV_BY_3};
            SEG_O4A: info = '{den: 9'd192, sh: 3'd6, m: DIV_BY_3};
            SEG_O4B: info = '{den: 9'd96,  sh: 3'd5, m: DIV_BY_3};
            SEG_O4C: info = '{den: 9'd384, sh: 3'd7, m: DIV_BY_3};
            SEG_O5A,
            SEG_O5B,
            SEG_O5C: info = '{den: 9'd120, sh: 3'd3, m: DIV_BY_15};
            default: info = '{den: 9'd1,   sh: 3'd0, m: DIV_BY_1};
        endcase
        return info;
    endfunction

    // floor(2^32 / m); the quotient estimate is at most one low
    function automatic logic [RECIP_W-1:0] div_recip(input logic [DIV_M_W-1:0] m);
        logic [RECIP_W-1:0] r;
        unique case (m)
            DIV_BY_3:  r = 33'd1431655765;
            DIV_BY_15: r = 33'd286331153;
            default:   r = 33'h1_0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/bspline_shape_weight_top.sv =====
// Each accepted input beat gives one result beat on the m_ side; while m_tready is high,
// throughput is one beat per cycle. Every stage holds one item and the ready chain lets
// bubbles fill while the output register waits. The 32x32 distance multiplier, five
// Horner multiply-accumulate stages and a reciprocal-multiply divider set the depth.
// Reset (aresetn low, synchronous) clears all stage valid bits, sets spline_order to 1
// and inverse_cell_width to 1.0; s_tready stays low while reset is held.
// Depends on bsw_pkg.

module bspline_shape_weight_top
    import bsw_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [31:0] offset (signed Q16.16)
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [16:0] weight (Q1.16), [23:17] zero
    output logic [M_TUSER_W-1:0]   m_tuser    // [0] outside_support
);

    // Internal widths
    localparam int DW    = FRAC_BITS + 3;            // clamped distance, up to 4.0
    localparam int XW    = FRAC_BITS + 2;            // polynomial variable, up to 2.0
    localparam int AW    = FRAC_BITS + 12;           // signed Horner accumulator
    localparam int PW    = AW + XW + 1;              // multiply-accumulate width
    localparam int DISTW = 2 * OFFSET_W - (OFFSET_W - FRAC_BITS);
    localparam int TW    = AW + WEIGHT_FRAC;         // scaled numerator
    localparam int VW    = TW - FRAC_BITS;           // numerator after the Q.F shift
    localparam int QPW   = VW + RECIP_W;

    // Stage map
    localparam int ST_MAG  = 0;
    localparam int ST_PROD = 1;
    localparam int ST_SEG  = 2;
    localparam int ST_DIV  = ST_SEG + HORNER_STEPS + 1;
    localparam int ST_QT   = ST_DIV + 1;
    localparam int ST_OUT  = ST_QT + 1;
    localparam int NSTG    = ST_OUT + 1;

    // Distance thresholds in Q.F
    localparam logic [DISTW-1:0] DIST_LIMIT = DISTW'(4) << FRAC_BITS;
    localparam logic [DW-1:0] D_HALF  = DW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] D_ONE   = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] D_3HALF = DW'(3) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] D_TWO   = DW'(2) << FRAC_BITS;
    localparam logic [DW-1:0] D_5HALF = DW'(5) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] D_THREE = DW'(3) << FRAC_BITS;
    localparam logic [DW:0]   X_TWO   = (DW+1)'(2) << FRAC_BITS;
    localparam logic [DW:0]   X_THREE = (DW+1)'(3) << FRAC_BITS;
    localparam logic [DW:0]   X_FIVE  = (DW+1)'(5) << FRAC_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (FRAC_BITS - 1);

    typedef struct packed {
        seg_t                 seg;
        logic [XW-1:0]        x;
        logic signed [AW-1:0] acc;
    } hstage_t;

    // Configuration registers
    logic [ORDER_W-1:0] order_reg;
    logic [ICW_W-1:0]   icw_reg;

    // Handshake control
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   stg_en;

    // Stage payloads
    logic [OFFSET_W-1:0]     mag_reg, mag_next;
    logic [2*OFFSET_W-1:0]   prod_reg, prod_next;
    hstage_t                 hst_reg [0:HORNER_STEPS];
    hstage_t                 hst_next[0:HORNER_STEPS];
    logic [VW-1:0]           dv_v_reg, dv_v_next;
    logic [DIV_M_W-1:0]      dv_m_reg, dv_m_next;
    logic                    dv_pos_reg, dv_pos_next;
    logic                    dv_out_reg, dv_out_next;
    logic [VW-1:0]           qt_q0_reg, qt_q0_next;
    logic [VW-1:0]           qt_v_reg;
    logic [DIV_M_W-1:0]      qt_m_reg;
    logic                    qt_pos_reg, qt_out_reg;
    logic [WEIGHT_W-1:0]     out_weight_reg, out_weight_next;
    logic                    out_flag_reg;

    // Segment select intermediates
    logic [DISTW-1:0] d_full;
    logic [DW-1:0]    d_val;
    logic [DW:0]      d_twice;
    seg_t             seg_sel;
    logic [XW-1:0]    x_sel;
    coef_row_t        seg_row;

    // Horner intermediates
    coef_row_t             h_row [0:HORNER_STEPS-1];
    logic signed [PW-1:0]  h_prod[0:HORNER_STEPS-1];
    logic signed [PW-1:0]  h_mac [0:HORNER_STEPS-1];

    // Division intermediates
    div_info_t       dv_info;
    logic [TW-1:0]   dv_num;
    logic [QPW-1:0]  qt_prod;
    logic [VW+DIV_M_W-1:0] fx_qm;
    logic [VW-1:0]   fx_rem;
    logic [VW-1:0]   fx_q;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
            icw_reg   <= ICW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SPLINE_ORDER:   order_reg <= cfg_wr_data[ORDER_W-1:0];
                REG_INV_CELL_WIDTH: icw_reg   <= cfg_wr_data[ICW_W-1:0];
                default:            order_reg <= order_reg;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its successor loads
    assign stg_en[NSTG] = m_tready;
    for (genvar i = 0; i < NSTG; i++) begin : g_en
        assign stg_en[i] = !vld_reg[i] || stg_en[i+1];
    end

    assign s_tready = stg_en[ST_MAG] && aresetn;
    assign m_tvalid = vld_reg[ST_OUT];

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NSTG; i++) begin
                if (stg_en[i]) begin
                    vld_reg[i] <= (i == 0) ? s_tvalid : vld_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    // Absolute offset and normalized distance product
    assign mag_next  = s_tdata[OFFSET_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign prod_next = mag_reg * icw_reg;

    // Truncate to Q.F, saturate at 4.0, pick the segment and its variable
    always_comb begin
        d_full  = prod_reg[2*OFFSET_W-1 : OFFSET_W-FRAC_BITS];
        d_val   = (d_full > DIST_LIMIT) ? DIST_LIMIT[DW-1:0] : d_full[DW-1:0];
        d_twice = {d_val, 1'b0};
        seg_sel = SEG_OUT;
        x_sel   = d_val[XW-1:0];
        unique case (order_reg)
            3'd0: begin
                if (d_val <= D_HALF) seg_sel = SEG_O0;
            end
            3'd1: begin
                if (d_val <= D_ONE) seg_sel = SEG_O1;
            end
            3'd2: begin
                if (d_val <= D_HALF) begin
                    seg_sel = SEG_O2A;
                end else if (d_val < D_3HALF) begin
                    seg_sel = SEG_O2B;
                    x_sel   = XW'(X_THREE - d_twice);
                end
            end
            3'd3: begin
                if (d_val < D_ONE) begin
                    seg_sel = SEG_O3A;
                end else if (d_val < D_TWO) begin
                    seg_sel = SEG_O3B;
                    x_sel   = XW'(X_TWO - {1'b0, d_val});
                end
            end
            3'd4: begin
                if (d_val <= D_HALF) begin
                    seg_sel = SEG_O4A;
                end else if (d_val <= D_3HALF) begin
                    seg_sel = SEG_O4B;
                end else if (d_val < D_5HALF) begin
                    seg_sel = SEG_O4C;
                    x_sel   = XW'(X_FIVE - d_twice);
                end
            end
            default: begin
                // order five and the unused codes above it
                if (d_val <= D_ONE) begin
                    seg_sel = SEG_O5A;
                end else if (d_val <= D_TWO) begin
                    seg_sel = SEG_O5B;
                end else if (d_val < D_THREE) begin
                    seg_sel = SEG_O5C;
                    x_sel   = XW'(X_THREE - {1'b0, d_val});
                end
            end
        endcase
        seg_row = seg_coefs(seg_sel);
    end

    // Horner: one multiply-accumulate per stage, rounded half up onto Q.F
    always_comb begin
        hst_next[0].seg = seg_sel;
        hst_next[0].x   = x_sel;
        hst_next[0].acc = AW'($signed(seg_row[HORNER_STEPS])) <<< FRAC_BITS;
        for (int k = 0; k < HORNER_STEPS; k++) begin
            h_row[k]  = seg_coefs(hst_reg[k].seg);
            h_prod[k] = hst_reg[k].acc * $signed({1'b0, hst_reg[k].x});
            h_mac[k]  = h_prod[k] + ROUND_HALF
                      + (PW'($signed(h_row[k][HORNER_STEPS-1-k])) <<< (2 * FRAC_BITS));
            hst_next[k+1].seg = hst_reg[k].seg;
            hst_next[k+1].x   = hst_reg[k].x;
            hst_next[k+1].acc = h_mac[k][AW+FRAC_BITS-1:FRAC_BITS];
        end
    end

    // Scale to Q1.16 with the rounding half of the denominator, strip 2^(F+sh)
    always_comb begin
        dv_info     = seg_div_info(hst_reg[HORNER_STEPS].seg);
        dv_num      = (TW'(hst_reg[HORNER_STEPS].acc[AW-2:0]) << WEIGHT_FRAC)
                    + (TW'(dv_info.den) << (FRAC_BITS - 1));
        dv_v_next   = VW'(dv_num >> (FRAC_BITS + dv_info.sh));
        dv_m_next   = dv_info.m;
        dv_pos_next = hst_reg[HORNER_STEPS].acc > 0;
        dv_out_next = hst_reg[HORNER_STEPS].seg == SEG_OUT;
    end

    // Quotient estimate by reciprocal multiply
    assign qt_prod    = dv_v_reg * div_recip(dv_m_reg);
    assign qt_q0_next = qt_prod[VW+RECIP_SHIFT-1:RECIP_SHIFT];

    // Correct the estimate by one, then clamp to 1.0; a non-positive accumulator gives zero
    always_comb begin
        fx_qm  = qt_q0_reg * qt_m_reg;
        fx_rem = qt_v_reg - fx_qm[VW-1:0];
        fx_q   = (fx_rem >= VW'(qt_m_reg)) ? VW'(qt_q0_reg + 1'b1) : qt_q0_reg;
        if (!qt_pos_reg) begin
            out_weight_next = '0;
        end else if (fx_q > VW'(WEIGHT_ONE)) begin
            out_weight_next = WEIGHT_ONE;
        end else begin
            out_weight_next = fx_q[WEIGHT_W-1:0];
        end
    end

    // Payload registers: load on stage advance
    always_ff @(posedge aclk) begin
        if (stg_en[ST_MAG]) begin
            mag_reg <= mag_next;
        end
        if (stg_en[ST_PROD]) begin
            prod_reg <= prod_next;
        end
        for (int k = 0; k <= HORNER_STEPS; k++) begin
            if (stg_en[ST_SEG+k]) begin
                hst_reg[k] <= hst_next[k];
            end
        end
        if (stg_en[ST_DIV]) begin
            dv_v_reg   <= dv_v_next;
            dv_m_reg   <= dv_m_next;
            dv_pos_reg <= dv_pos_next;
            dv_out_reg <= dv_out_next;
        end
        if (stg_en[ST_QT]) begin
            qt_q0_reg  <= qt_q0_next;
            qt_v_reg   <= dv_v_reg;
            qt_m_reg   <= dv_m_reg;
            qt_pos_reg <= dv_pos_reg;
            qt_out_reg <= dv_out_reg;
        end
        if (stg_en[ST_OUT]) begin
            out_weight_reg <= out_weight_next;
            out_flag_reg   <= qt_out_reg;
        end
    end

    // Result beat
    assign m_tdata = {(M_TDATA_W-WEIGHT_W)'(0), out_weight_reg};
    assign m_tuser = out_flag_reg;

endmodule

// ===== rtl/core/bsw_checker.sv =====
// Port-level checks for bspline_shape_weight_top, attached by the bind at the end.
// Depends on bsw_pkg.

module bsw_checker
    import bsw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // [16:0] weight, [23:17] zero
    input logic [M_TUSER_W-1:0] m_tuser    // [0] outside_support
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A free output lets every stage advance, so the input side must be ready
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input not ready while output is free");

    // Outside the support the weight is zero
    a_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[WEIGHT_W-1:0] == '0)
        else $error("nonzero weight outside support");

    // Weight stays within 1.0 and the pad bits stay clear
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[WEIGHT_W-1:0] <= WEIGHT_ONE
                     && m_tdata[M_TDATA_W-1:WEIGHT_W] == '0)
        else $error("weight out of range");

    // Reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bspline_shape_weight_top bsw_checker u_bsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
